### design/spq_pkg.sv
// spq_pkg: types, result kinds and command codes for the sorted priority queue.
// Used by every module of the block; depends on nothing.
`default_nettype none
package spq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int CQ_DEPTH      = 2;

   localparam logic [1:0] KIND_INSERTED = 2'd0;
   localparam logic [1:0] KIND_DROPPED  = 2'd1;
   localparam logic [1:0] KIND_ENTRY    = 2'd2;
   localparam logic [1:0] KIND_EMPTY    = 2'd3;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DROP   = 2'd1;
   localparam logic [1:0] CMD_LIST   = 2'd2;
   localparam logic [1:0] CMD_EMPTY  = 2'd3;

   localparam logic OP_INSERT = 1'b0;

   typedef struct packed {
      logic               op;
      logic signed [31:0] item_value;
      logic signed [31:0] item_priority;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] entry_value;
      logic signed [31:0] entry_priority;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         code;
      logic signed [31:0] value;
      logic signed [31:0] prio;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_push_type;

endpackage
`default_nettype wire

### design/sorted_priority_queue.sv
// sorted_priority_queue: top level, front classifier, command queue and cell row.
// Depends on spq_pkg, spq_front, spq_cmd_fifo and spq_back.
//
//   channel  ports                          beat
//   req      req_valid req_ready req_data   one insert or list request
//   rsp      rsp_valid rsp_ready rsp_data   one result, last on the final one
//
// An insert, drop or empty command gives a single result from the cell row.
// A list of n entries gives n results, one per entry, by rotating the cell row.
// Reset clears the fill count and handshake state; entry cells hold no reset.
// The command queue lets requests enter while results stall on rsp_ready.
`default_nettype none
module sorted_priority_queue import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_push_type push;
   logic         push_ready;
   logic         q_valid;
   cmd_type      q_cmd;
   logic         q_pop;

   spq_front #(.DEPTH(DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_ready (push_ready)
   );

   spq_cmd_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .pop        (q_pop)
   );

   spq_back #(.DEPTH(DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### design/spq_front.sv
// spq_front: accepts request beats and classifies them against a predicted fill count.
// Depends on spq_pkg.
`default_nettype none
module spq_front import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_type      req_data,
   output cmd_push_type      push,
   input  wire logic         push_ready
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          full;
   logic          accept;

   assign full      = (count_ff == CW'(DEPTH));
   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   always_comb begin
      push.valid     = req_valid;
      push.cmd.value = req_data.item_value;
      push.cmd.prio  = req_data.item_priority;
      count_in       = count_ff;
      if (req_data.op == OP_INSERT) begin
         if (full) begin
            push.cmd.code = CMD_DROP;
         end else begin
            push.cmd.code = CMD_INSERT;
            if (accept) count_in = count_ff + CW'(1);
         end
      end else begin
         push.cmd.code = (count_ff == '0) ? CMD_EMPTY : CMD_LIST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### design/spq_cmd_fifo.sv
// spq_cmd_fifo: short command queue between the front and the back.
// Depends on spq_pkg.
`default_nettype none
module spq_cmd_fifo import spq_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cmd_push_type push,
   output logic              push_ready,
   output logic              pop_valid,
   output cmd_type           pop_cmd,
   input  wire logic         pop
);

   localparam int PW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
   localparam int NW = $clog2(CQ_DEPTH + 1);

   cmd_type       slots_ff [CQ_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign push_ready = (fill_ff != NW'(CQ_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_cmd    = slots_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) fill_in = fill_ff + NW'(1);
      if (!do_push && do_pop) fill_in = fill_ff - NW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push.cmd;
   end

endmodule
`default_nettype wire

### design/spq_back.sv
// spq_back: row of sorted entry cells, parallel shifting insert, listing by rotation,
// and the result register. Depends on spq_pkg.
`default_nettype none
module spq_back import spq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_LIST = 1'b1;

   logic signed [31:0] vals_ff [DEPTH];
   logic signed [31:0] vals_in [DEPTH];
   logic signed [31:0] pris_ff [DEPTH];
   logic signed [31:0] pris_in [DEPTH];
   logic [DEPTH-1:0]   greater;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic          state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          out_free;
   logic          do_insert, do_rotate;
   logic          list_last;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign list_last = (idx_ff == count_ff - CW'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      do_insert    = 1'b0;
      do_rotate    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: KIND_INSERTED, entry_value: '0,
                                entry_priority: '0, last: 1'b1};
               unique case (cmd.code)
                  CMD_INSERT: begin
                     do_insert = 1'b1;
                     count_in  = count_ff + CW'(1);
                  end
                  CMD_DROP:  rsp_in.kind = KIND_DROPPED;
                  CMD_EMPTY: rsp_in.kind = KIND_EMPTY;
                  CMD_LIST: begin
                     rsp_in = '{kind: KIND_ENTRY, entry_value: vals_ff[0],
                                entry_priority: pris_ff[0],
                                last: (count_ff == CW'(1))};
                     do_rotate = 1'b1;
                     if (count_ff != CW'(1)) begin
                        state_in = ST_LIST;
                        idx_in   = CW'(1);
                     end
                  end
                  default: rsp_valid_in = rsp_valid_ff && !rsp_ready;
               endcase
            end
         end
         ST_LIST: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: KIND_ENTRY, entry_value: vals_ff[0],
                                entry_priority: pris_ff[0], last: list_last};
               do_rotate    = 1'b1;
               idx_in       = idx_ff + CW'(1);
               if (list_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Greater flags form a prefix; the first clear flag marks the insert slot.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         greater[i] = (CW'(i) < count_ff) && (pris_ff[i] > cmd.prio);
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         vals_in[i] = vals_ff[i];
         pris_in[i] = pris_ff[i];
         if (do_insert && !greater[i]) begin
            if (i == 0 || greater[(i == 0) ? 0 : i - 1]) begin
               vals_in[i] = cmd.value;
               pris_in[i] = cmd.prio;
            end else begin
               vals_in[i] = vals_ff[(i == 0) ? 0 : i - 1];
               pris_in[i] = pris_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (do_rotate) begin
            if (i == DEPTH - 1 || CW'(i) == count_ff - CW'(1)) begin
               vals_in[i] = vals_ff[0];
               pris_in[i] = pris_ff[0];
            end else begin
               vals_in[i] = vals_ff[(i == DEPTH - 1) ? 0 : i + 1];
               pris_in[i] = pris_ff[(i == DEPTH - 1) ? 0 : i + 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      for (int i = 0; i < DEPTH; i++) begin
         vals_ff[i] <= vals_in[i];
         pris_ff[i] <= pris_in[i];
      end
   end

endmodule
`default_nettype wire

### bench/tb_sorted_priority_queue.sv
// tb_sorted_priority_queue: self-checking bench for the sorted priority queue.
// Directed table then random beats, scored against a sorted-list predictor.
// Depends on spq_pkg and sorted_priority_queue.
module tb_sorted_priority_queue;
   import spq_pkg::*;

   localparam int   QUEUE_DEPTH  = DEPTH_DEFAULT;
   localparam logic OP_LIST      = ~OP_INSERT;
   localparam int   RANDOM_ITEMS = 108;
   localparam int   STALL_LIMIT  = 4000;
   localparam int   DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
   localparam int   PRINT_CAP    = 40;

   localparam rsp_type DONE_INSERT = rsp_type'({KIND_INSERTED, 32'sd0, 32'sd0, 1'b1});
   localparam rsp_type DONE_DROP   = rsp_type'({KIND_DROPPED, 32'sd0, 32'sd0, 1'b1});
   localparam rsp_type DONE_EMPTY  = rsp_type'({KIND_EMPTY, 32'sd0, 32'sd0, 1'b1});
   localparam rsp_type NO_PIN      = '0;

   typedef struct packed {
      req_type beat;
      logic    pinned;
      rsp_type pin;
   } table_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic steady = 1'b0;

   table_row_type stimulus_table[$];
   table_row_type pending_pins[$];
   rsp_type       awaited_results[$];

   logic signed [31:0] kept_value    [QUEUE_DEPTH];
   logic signed [31:0] kept_priority [QUEUE_DEPTH];
   int kept_count = 0;

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int stored_count   = 0;
   int dropped_count  = 0;
   int list_count     = 0;
   int listed_entries = 0;
   int compared_count = 0;

   sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 24);
   end

   task automatic log_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) begin
         $display("MISMATCH @%0t: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   // Sorted-list queue: insert before the first entry with priority not strictly greater.
   task automatic predict_queue_results(input req_type beat, input bit emit);
      int pos;
      int i;
      rsp_type res;
      if (beat.op == OP_INSERT) begin
         if (kept_count >= QUEUE_DEPTH) begin
            dropped_count++;
            if (emit) awaited_results.push_back(DONE_DROP);
         end else begin
            pos = 0;
            while (pos < kept_count && kept_priority[pos] > beat.item_priority) pos++;
            for (i = kept_count; i > pos; i--) begin
               kept_value[i]    = kept_value[i - 1];
               kept_priority[i] = kept_priority[i - 1];
            end
            kept_value[pos]    = beat.item_value;
            kept_priority[pos] = beat.item_priority;
            kept_count++;
            stored_count++;
            if (emit) awaited_results.push_back(DONE_INSERT);
         end
      end else begin
         list_count++;
         if (kept_count == 0) begin
            if (emit) awaited_results.push_back(DONE_EMPTY);
         end else begin
            for (i = 0; i < kept_count; i++) begin
               res.kind           = KIND_ENTRY;
               res.entry_value    = kept_value[i];
               res.entry_priority = kept_priority[i];
               res.last           = (i == kept_count - 1);
               if (emit) awaited_results.push_back(res);
            end
            listed_entries += kept_count;
         end
      end
   endtask

   always @(posedge clock) begin
      table_row_type pin_row;
      rsp_type       want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pin_row = pending_pins.pop_front();
            predict_queue_results(req_data, !pin_row.pinned);
            if (pin_row.pinned) awaited_results.push_back(pin_row.pin);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               log_mismatch($sformatf("result with nothing awaited, kind %0d", rsp_data.kind));
            end else begin
               want = awaited_results.pop_front();
               compared_count++;
               if (rsp_data.kind !== want.kind)
                  log_mismatch($sformatf("kind got %0d want %0d", rsp_data.kind, want.kind));
               if (rsp_data.entry_value !== want.entry_value)
                  log_mismatch($sformatf("entry_value got %h want %h",
                                         rsp_data.entry_value, want.entry_value));
               if (rsp_data.entry_priority !== want.entry_priority)
                  log_mismatch($sformatf("entry_priority got %h want %h",
                                         rsp_data.entry_priority, want.entry_priority));
               if (rsp_data.last !== want.last)
                  log_mismatch($sformatf("last got %0b want %0b", rsp_data.last, want.last));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                        STALL_LIMIT, awaited_results.size());
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   task automatic add_row(input logic op, input logic [31:0] value, input logic [31:0] prio,
                          input logic pinned, input rsp_type pin);
      table_row_type row;
      row.beat.op            = op;
      row.beat.item_value    = value;
      row.beat.item_priority = prio;
      row.pinned             = pinned;
      row.pin                = pin;
      stimulus_table.push_back(row);
   endtask

   // Called at a rising edge; returns at a rising edge.
   task automatic send_beat(input table_row_type row);
      pending_pins.push_back(row);
      req_valid <= 1'b1;
      req_data  <= row.beat;
      do @(posedge clock); while (!req_ready);
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 24);
      end
   endtask

   initial begin
      table_row_type row;
      add_row(OP_LIST,   32'h0,        32'h0,        1'b1, DONE_EMPTY);
      add_row(OP_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1, DONE_INSERT);
      add_row(OP_INSERT, 32'h80000000, 32'h80000000, 1'b1, DONE_INSERT);
      add_row(OP_LIST,   32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h00000000, 32'h00000000, 1'b0, NO_PIN);
      // equal priorities: newest first
      add_row(OP_INSERT, 32'hFFFFFFFF, 32'h00000000, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h00000001, 32'h00000000, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h00000005, 32'h7FFFFFFF, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h00000006, 32'h80000000, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'hFFFFFFFB, 32'hFFFFFFFF, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'hA5A5A5A5, 32'h00000001, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h5A5A5A5A, 32'hFFFFFFFE, 1'b0, NO_PIN);
      add_row(OP_LIST,   32'h0,        32'h0,        1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h12345678, 32'h00000064, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h7FFFFFFF, 32'hFFFFFF9C, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h80000000, 32'h00000064, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h0F0F0F0F, 32'h00000002, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'hF0F0F0F0, 32'hFFFFFFFE, 1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h33333333, 32'h00000000, 1'b0, NO_PIN);
      // queue now full
      add_row(OP_INSERT, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b1, DONE_DROP);
      add_row(OP_LIST,   32'h0,        32'h0,        1'b0, NO_PIN);
      add_row(OP_INSERT, 32'h00000000, 32'h80000000, 1'b1, DONE_DROP);
      add_row(OP_LIST,   32'hFFFFFFFF, 32'h00000000, 1'b0, NO_PIN);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stimulus_table[k]) send_beat(stimulus_table[k]);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 40 && n < 80);
         row.beat.op         = ($urandom_range(2) == 0) ? OP_LIST : OP_INSERT;
         row.beat.item_value = $urandom;
         case ($urandom_range(3))
            0:       row.beat.item_priority = $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
            1:       row.beat.item_priority = $urandom_range(7) - 4;
            default: row.beat.item_priority = $urandom;
         endcase
         row.pinned = 1'b0;
         row.pin    = NO_PIN;
         send_beat(row);
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d stored, %0d dropped on a full queue, %0d lists",
               stimulus_table.size() + RANDOM_ITEMS, stored_count, dropped_count, list_count);
      $display("%0d entries listed, %0d results compared, %0d mismatches",
               listed_entries, compared_count, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

### sim.f
design/spq_pkg.sv
design/spq_front.sv
design/spq_cmd_fifo.sv
design/spq_back.sv
design/sorted_priority_queue.sv
bench/tb_sorted_priority_queue.sv
